FILE: hw/rtl/sab_pkg.sv
`default_nettype none

package sab_pkg;

    // Position counters cover up to MAX_DIM columns and rows.
    localparam int unsigned MAX_DIM   = 1024;
    localparam int unsigned POS_W     = $clog2(MAX_DIM);
    localparam int unsigned DIM_W     = POS_W + 1;
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned ALPHA_W   = 4;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned IN_DATA_W = 56;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned OUT_USER_W = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = {ALPHA_W{1'b1}};
    localparam logic [DIM_W-1:0]   DIM_MAX   = DIM_W'(MAX_DIM);

    // Register file indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_SUB_WIDTH    = 3'd0,
        REG_SUB_HEIGHT   = 3'd1,
        REG_CROP_ENABLE  = 3'd2,
        REG_CROP_X_FIRST = 3'd3,
        REG_CROP_X_LAST  = 3'd4,
        REG_CROP_Y_FIRST = 3'd5,
        REG_CROP_Y_LAST  = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [DIM_W-1:0] sub_width;
        logic [DIM_W-1:0] sub_height;
        logic             crop_enable;
        logic [POS_W-1:0] crop_x_first;
        logic [POS_W-1:0] crop_x_last;
        logic [POS_W-1:0] crop_y_first;
        logic [POS_W-1:0] crop_y_last;
    } t_cfg;

    // Input beat, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]          pad;
        logic [SAMPLE_W-1:0] under_cr;
        logic [SAMPLE_W-1:0] under_cb;
        logic [SAMPLE_W-1:0] under_luma;
        logic [ALPHA_W-1:0]  alpha;
        logic [SAMPLE_W-1:0] sub_cr;
        logic [SAMPLE_W-1:0] sub_cb;
        logic [SAMPLE_W-1:0] sub_luma;
    } t_pix_in;

    // Raster position of one pixel.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } t_pos;

    // Result beat.
    typedef struct packed {
        logic                last_pixel;
        logic                write_chroma;
        logic                write_luma;
        logic [SAMPLE_W-1:0] out_cr;
        logic [SAMPLE_W-1:0] out_cb;
        logic [SAMPLE_W-1:0] out_luma;
    } t_pix_out;

endpackage

`default_nettype wire

FILE: hw/rtl/sab_cfg.sv
`default_nettype none

module sab_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sab_pkg::APB_AW-1:0]   paddr,
    input  wire logic [sab_pkg::APB_DW-1:0]   pwdata,
    output logic      [sab_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output sab_pkg::t_cfg                     o_cfg
);
    import sab_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes complete in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sub_width    <= DIM_W'(720);
            r_cfg.sub_height   <= DIM_W'(576);
            r_cfg.crop_enable  <= 1'b0;
            r_cfg.crop_x_first <= '0;
            r_cfg.crop_x_last  <= '1;
            r_cfg.crop_y_first <= '0;
            r_cfg.crop_y_last  <= '1;
        end else if (wr_en) begin
            unique case (idx)
                REG_SUB_WIDTH:    r_cfg.sub_width    <= pwdata[DIM_W-1:0];
                REG_SUB_HEIGHT:   r_cfg.sub_height   <= pwdata[DIM_W-1:0];
                REG_CROP_ENABLE:  r_cfg.crop_enable  <= pwdata[0];
                REG_CROP_X_FIRST: r_cfg.crop_x_first <= pwdata[POS_W-1:0];
                REG_CROP_X_LAST:  r_cfg.crop_x_last  <= pwdata[POS_W-1:0];
                REG_CROP_Y_FIRST: r_cfg.crop_y_first <= pwdata[POS_W-1:0];
                REG_CROP_Y_LAST:  r_cfg.crop_y_last  <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (idx)
            REG_SUB_WIDTH:    prdata = APB_DW'(r_cfg.sub_width);
            REG_SUB_HEIGHT:   prdata = APB_DW'(r_cfg.sub_height);
            REG_CROP_ENABLE:  prdata = APB_DW'(r_cfg.crop_enable);
            REG_CROP_X_FIRST: prdata = APB_DW'(r_cfg.crop_x_first);
            REG_CROP_X_LAST:  prdata = APB_DW'(r_cfg.crop_x_last);
            REG_CROP_Y_FIRST: prdata = APB_DW'(r_cfg.crop_y_first);
            REG_CROP_Y_LAST:  prdata = APB_DW'(r_cfg.crop_y_last);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sab_pos.sv
`default_nettype none

module sab_pos (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sab_pkg::t_cfg i_cfg,
    input  wire logic          i_advance,
    output sab_pkg::t_pos      o_pos
);
    import sab_pkg::*;

    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             row_end;
    logic             frame_end;

    // Zero size acts as one, oversize acts as the maximum.
    always_comb begin
        if (i_cfg.sub_width == '0) begin
            width = DIM_W'(1);
        end else if (i_cfg.sub_width > DIM_MAX) begin
            width = DIM_MAX;
        end else begin
            width = i_cfg.sub_width;
        end
        if (i_cfg.sub_height == '0) begin
            height = DIM_W'(1);
        end else if (i_cfg.sub_height > DIM_MAX) begin
            height = DIM_MAX;
        end else begin
            height = i_cfg.sub_height;
        end
    end

    assign col_inc   = {1'b0, r_col} + DIM_W'(1);
    assign row_inc   = {1'b0, r_row} + DIM_W'(1);
    assign row_end   = col_inc >= width;
    assign frame_end = row_end && (row_inc >= height);

    assign o_pos.x    = r_col;
    assign o_pos.y    = r_row;
    assign o_pos.last = frame_end;

    // Raster counters step once per accepted beat and wrap after the last pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : row_inc[POS_W-1:0];
            end else begin
                r_col <= col_inc[POS_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sab_blend.sv
`default_nettype none

module sab_blend (
    input  wire sab_pkg::t_cfg    i_cfg,
    input  wire sab_pkg::t_pix_in i_pix,
    input  wire sab_pkg::t_pos    i_pos,
    output sab_pkg::t_pix_out     o_res
);
    import sab_pkg::*;

    logic cropped;
    logic opaque;
    logic wl;
    logic wc;

    // Blend (s*a + u*(15-a)) >> 4; the result never exceeds 239.
    function automatic logic [SAMPLE_W-1:0] mix(
        input logic [SAMPLE_W-1:0] s,
        input logic [SAMPLE_W-1:0] u,
        input logic [ALPHA_W-1:0]  a
    );
        logic [ALPHA_W-1:0]            inv;
        logic [SAMPLE_W+ALPHA_W-1:0]   sum;
        inv = ALPHA_MAX - a;
        sum = ({{ALPHA_W{1'b0}}, s} * {{SAMPLE_W{1'b0}}, a})
            + ({{ALPHA_W{1'b0}}, u} * {{SAMPLE_W{1'b0}}, inv});
        return sum[SAMPLE_W+ALPHA_W-1:ALPHA_W];
    endfunction

    // Crop window test, bounds inclusive; an inverted window is empty.
    assign cropped = i_cfg.crop_enable &&
                     ((i_pos.x < i_cfg.crop_x_first) || (i_pos.x > i_cfg.crop_x_last) ||
                      (i_pos.y < i_cfg.crop_y_first) || (i_pos.y > i_cfg.crop_y_last));
    assign opaque  = i_pix.alpha == ALPHA_MAX;
    assign wl      = !cropped && (i_pix.alpha != '0);
    // Chroma is sited at even rows and even columns.
    assign wc      = wl && !i_pos.x[0] && !i_pos.y[0];

    // Unwritten samples pass the frame value through.
    always_comb begin
        o_res.last_pixel   = i_pos.last;
        o_res.write_luma   = wl;
        o_res.write_chroma = wc;
        o_res.out_luma     = i_pix.under_luma;
        o_res.out_cb       = i_pix.under_cb;
        o_res.out_cr       = i_pix.under_cr;
        if (wl) begin
            o_res.out_luma = opaque ? i_pix.sub_luma
                                    : mix(i_pix.sub_luma, i_pix.under_luma, i_pix.alpha);
        end
        if (wc) begin
            o_res.out_cb = opaque ? i_pix.sub_cb
                                  : mix(i_pix.sub_cb, i_pix.under_cb, i_pix.alpha);
            o_res.out_cr = opaque ? i_pix.sub_cr
                                  : mix(i_pix.sub_cr, i_pix.under_cr, i_pix.alpha);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/subtitle_alpha_blend_yuv420.sv
// Subtitle overlay for a 4:2:0 planar frame.
// The slave stream carries one subtitle pixel per beat in raster order,
// together with the frame's Y and co-sited U, V samples. The master stream
// returns exactly one beat per input beat: the new Y, U, V values, write
// enables for luma and chroma in tuser, and tlast on the final pixel of the
// subtitle. Chroma is written only at even rows and even columns.
// An input register captures the beat and its raster position, then the
// blend and crop logic feed the result register. Throughput is one pixel
// per clock unless the receiver stalls; the two register stages let a new
// beat enter while a finished result still waits on the master side.
// When the receiver stalls, the result register holds and the input stage
// fills; tready drops only when both stages are occupied. The user must
// write the APB size and crop registers while the stream is idle; the block
// does not enforce this. Synchronous reset empties both stages, returns the
// raster counters to the first pixel and loads the register defaults.
`default_nettype none

module subtitle_alpha_blend_yuv420 (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Fields from bit 0: sub_luma, sub_cb, sub_cr, alpha, under_luma,
    // under_cb, under_cr, zero pad.
    input  wire logic [sab_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Fields from bit 0: out_luma, out_cb, out_cr.
    output logic      [sab_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // Fields from bit 0: write_luma, write_chroma.
    output logic      [sab_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    output logic                                  o_m_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sab_pkg::APB_AW-1:0]       paddr,
    input  wire logic [sab_pkg::APB_DW-1:0]       pwdata,
    output logic      [sab_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready
);
    import sab_pkg::*;

    t_cfg     cfg;
    t_pos     pos;
    t_pix_out blend_res;
    logic     in_accept;
    logic     s1_ready;
    logic     s2_ready;

    logic     r_v1;
    t_pix_in  r_pix1;
    t_pos     r_pos1;
    logic     r_v2;
    t_pix_out r_res2;

    sab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sab_pos u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (in_accept),
        .o_pos     (pos)
    );

    sab_blend u_blend (
        .i_cfg (cfg),
        .i_pix (r_pix1),
        .i_pos (r_pos1),
        .o_res (blend_res)
    );

    // Stage handshakes: each stage moves when the next one can take it.
    assign s2_ready        = !r_v2 || i_m_axis_tready;
    assign s1_ready        = !r_v1 || s2_ready;
    assign o_s_axis_tready = s1_ready;
    assign in_accept       = i_s_axis_tvalid && s1_ready;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix1 <= t_pix_in'(i_s_axis_tdata);
            r_pos1 <= pos;
        end
        if (s2_ready && r_v1) begin
            r_res2 <= blend_res;
        end
    end

    // Result beat.
    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = {r_res2.out_cr, r_res2.out_cb, r_res2.out_luma};
    assign o_m_axis_tuser  = {r_res2.write_chroma, r_res2.write_luma};
    assign o_m_axis_tlast  = r_res2.last_pixel;

endmodule

`default_nettype wire
